@@ rtl/core/trce_pkg.sv @@
// ----------------------------------------------------------------------------
// trce_pkg
// Shared widths, op and status codes, decode helpers and the register file
// access structs of the tiny register CPU execute unit.
// ----------------------------------------------------------------------------
package trce_pkg;

  localparam int DATA_W        = 8;
  localparam int PC_W          = 9;
  localparam int OP_W          = 4;
  localparam int IDX_W         = 8;
  localparam int STATUS_W      = 3;
  localparam int STEP_W        = 16;
  localparam int REG_COUNT_DEF = 8;
  localparam int MEM_BYTES_DEF = 256;

  localparam logic [STEP_W-1:0] CYCLE_LIMIT_RST = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 4'd0,
    OP_MOV   = 4'd1,
    OP_ADD   = 4'd2,
    OP_AND   = 4'd3,
    OP_OR    = 4'd4,
    OP_XOR   = 4'd5,
    OP_NOT   = 4'd6,
    OP_JMP   = 4'd7,
    OP_JZ    = 4'd8,
    OP_PRINT = 4'd9,
    OP_HALT  = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_HALTED   = 3'd1,
    ST_BAD_REG  = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_PC_RANGE = 3'd4,
    ST_LIMIT    = 3'd5
  } status_t;

  // Register file read request, issued when an input beat is taken.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } rf_rd_t;

  // Register file write, issued by the execute stage.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

  // Instruction byte length; unknown codes count as one byte.
  function automatic logic [1:0] op_length(input logic [OP_W-1:0] op);
    logic [1:0] len;
    if (op <= OP_XOR) begin
      len = 2'd3;
    end else if (op <= OP_PRINT) begin
      len = 2'd2;
    end else begin
      len = 2'd1;
    end
    return len;
  endfunction

  function automatic logic uses_dest(input logic [OP_W-1:0] op);
    return (op inside {[OP_LOAD:OP_NOT], OP_PRINT});
  endfunction

  function automatic logic uses_source(input logic [OP_W-1:0] op);
    return (op inside {[OP_MOV:OP_XOR]});
  endfunction

endpackage

@@ rtl/core/trce_in_if.sv @@
// ----------------------------------------------------------------------------
// trce_in_if
// Instruction channel: valid/ready handshake with one decoded instruction.
// ----------------------------------------------------------------------------
interface trce_in_if import trce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  dest_index;
  logic [IDX_W-1:0]  source_index;
  logic [DATA_W-1:0] immediate;

  modport source (output valid, op, dest_index, source_index, immediate,
                  input ready);
  modport sink   (input valid, op, dest_index, source_index, immediate,
                  output ready);
endinterface

@@ rtl/core/trce_out_if.sv @@
// ----------------------------------------------------------------------------
// trce_out_if
// Result channel: valid/ready handshake with one execution result.
// ----------------------------------------------------------------------------
interface trce_out_if import trce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PC_W-1:0]     next_pc;
  logic                print_valid;
  logic [DATA_W-1:0]   print_value;
  logic                zero_flag;
  logic                carry_flag;
  logic                stopped;

  modport source (output valid, status, next_pc, print_valid, print_value,
                  zero_flag, carry_flag, stopped, input ready);
  modport sink   (input valid, status, next_pc, print_valid, print_value,
                  zero_flag, carry_flag, stopped, output ready);
endinterface

@@ rtl/core/trce_regfile.sv @@
// ----------------------------------------------------------------------------
// trce_regfile
// Register file memory: two synchronous read ports, one write port, per
// entry valid bits for the zero reset value, and a one-entry bypass for a
// write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module trce_regfile import trce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rf_rd_t            rd,
  input  rf_wr_t            wr,
  output logic [DATA_W-1:0] data_a,
  output logic [DATA_W-1:0] data_b
);

  localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [DATA_W-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;

  logic [RIDX_W-1:0] raddr_a;
  logic [RIDX_W-1:0] raddr_b;
  logic [RIDX_W-1:0] waddr;

  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic [RIDX_W-1:0] addr_a_q;
  logic [RIDX_W-1:0] addr_b_q;

  logic              byp_en;
  logic [RIDX_W-1:0] byp_addr;
  logic [DATA_W-1:0] byp_data;

  assign raddr_a = rd.addr_a[RIDX_W-1:0];
  assign raddr_b = rd.addr_b[RIDX_W-1:0];
  assign waddr   = wr.addr[RIDX_W-1:0];

  // Read old contents; a same-edge write is caught by the bypass.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    if (rd.en) begin
      rdata_a  <= vld[raddr_a] ? mem[raddr_a] : '0;
      rdata_b  <= vld[raddr_b] ? mem[raddr_b] : '0;
      addr_a_q <= raddr_a;
      addr_b_q <= raddr_b;
      byp_addr <= waddr;
      byp_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      byp_en <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[waddr] <= 1'b1;
      end
      if (rd.en) begin
        byp_en <= wr.en;
      end
    end
  end

  assign data_a = (byp_en && byp_addr == addr_a_q) ? byp_data : rdata_a;
  assign data_b = (byp_en && byp_addr == addr_b_q) ? byp_data : rdata_b;

endmodule

@@ rtl/core/trce_exec.sv @@
// ----------------------------------------------------------------------------
// trce_exec
// Execute stage: holds the instruction whose operands are being read,
// checks it, updates pc, flags, halt mark and step count, writes back to
// the register file and loads the result register.
// ----------------------------------------------------------------------------
module trce_exec import trce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF,
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data,
  trce_in_if.sink           in_ch,
  trce_out_if.source        out_ch,
  input  logic [DATA_W-1:0] data_a,
  input  logic [DATA_W-1:0] data_b,
  output rf_wr_t            wr
);

  localparam logic [IDX_W:0] REG_LIMIT = (IDX_W+1)'(REG_COUNT);
  localparam logic [PC_W:0]  MEM_LIMIT = (PC_W+1)'(MEM_BYTES);

  // Instruction stage
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [IDX_W-1:0]  s1_dest;
  logic [IDX_W-1:0]  s1_src;
  logic [DATA_W-1:0] s1_imm;

  // Machine state
  logic [PC_W-1:0]   pc;
  logic              zero;
  logic              carry;
  logic              halted;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] cycle_limit;

  logic              fire;
  logic [PC_W:0]     end_pc;
  logic              reg_bad;
  logic [DATA_W:0]   sum;

  status_t           status_next;
  logic [PC_W-1:0]   pc_next;
  logic              zero_next;
  logic              carry_next;
  logic              halted_next;
  logic [STEP_W-1:0] step_count_next;
  logic              print_valid_next;
  logic [DATA_W-1:0] print_value_next;

  assign fire        = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || fire;

  assign end_pc  = {1'b0, pc} + (PC_W+1)'(op_length(s1_op));
  assign reg_bad = (uses_dest(s1_op) && {1'b0, s1_dest} >= REG_LIMIT) ||
                   (uses_source(s1_op) && {1'b0, s1_src} >= REG_LIMIT);
  assign sum     = {1'b0, data_a} + {1'b0, data_b};

  always_comb begin
    status_next      = ST_OK;
    pc_next          = pc;
    zero_next        = zero;
    carry_next       = carry;
    halted_next      = halted;
    step_count_next  = step_count;
    print_valid_next = 1'b0;
    print_value_next = '0;
    wr.en            = 1'b0;
    wr.addr          = s1_dest;
    wr.data          = s1_imm;
    if (halted) begin
      status_next = ST_HALTED;
    end else if (step_count >= cycle_limit) begin
      status_next = ST_LIMIT;
      halted_next = 1'b1;
    end else if (end_pc > MEM_LIMIT) begin
      status_next = ST_PC_RANGE;
      halted_next = 1'b1;
    end else if (s1_op > OP_HALT) begin
      status_next = ST_BAD_OP;
      halted_next = 1'b1;
    end else if (reg_bad) begin
      status_next = ST_BAD_REG;
      halted_next = 1'b1;
    end else begin
      step_count_next = step_count + STEP_W'(1);
      pc_next         = end_pc[PC_W-1:0];
      case (op_t'(s1_op))
        OP_LOAD: begin
          wr.en = 1'b1;
        end
        OP_MOV: begin
          wr.en   = 1'b1;
          wr.data = data_b;
        end
        OP_ADD: begin
          wr.en      = 1'b1;
          wr.data    = sum[DATA_W-1:0];
          zero_next  = (sum[DATA_W-1:0] == '0);
          carry_next = sum[DATA_W];
        end
        OP_AND, OP_OR, OP_XOR, OP_NOT: begin
          wr.en = 1'b1;
          case (op_t'(s1_op))
            OP_AND:  wr.data = data_a & data_b;
            OP_OR:   wr.data = data_a | data_b;
            OP_XOR:  wr.data = data_a ^ data_b;
            default: wr.data = ~data_a;
          endcase
          zero_next = (wr.data == '0);
        end
        OP_JMP: begin
          pc_next = PC_W'(s1_imm);
        end
        OP_JZ: begin
          if (zero) begin
            pc_next = PC_W'(s1_imm);
          end
        end
        OP_PRINT: begin
          print_valid_next = 1'b1;
          print_value_next = data_a;
        end
        default: begin
          halted_next = 1'b1;
        end
      endcase
    end
    // Write only when the stage actually advances.
    wr.en = wr.en && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
      pc           <= '0;
      zero         <= 1'b0;
      carry        <= 1'b0;
      halted       <= 1'b0;
      step_count   <= '0;
      cycle_limit  <= CYCLE_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        cycle_limit <= cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_ch.valid <= 1'b1;
        pc           <= pc_next;
        zero         <= zero_next;
        carry        <= carry_next;
        halted       <= halted_next;
        step_count   <= step_count_next;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op   <= in_ch.op;
      s1_dest <= in_ch.dest_index;
      s1_src  <= in_ch.source_index;
      s1_imm  <= in_ch.immediate;
    end
    if (fire) begin
      out_ch.status      <= status_next;
      out_ch.next_pc     <= pc_next;
      out_ch.print_valid <= print_valid_next;
      out_ch.print_value <= print_value_next;
      out_ch.zero_flag   <= zero_next;
      out_ch.carry_flag  <= carry_next;
      out_ch.stopped     <= halted_next;
    end
  end

endmodule

@@ rtl/core/tiny_register_cpu_execute_unit.sv @@
// ----------------------------------------------------------------------------
// tiny_register_cpu_execute_unit
// Executes one decoded instruction of a small 8-bit register machine per
// input beat and returns one result beat per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries op, dest_index, source_index and immediate; a beat moves
//          when valid and ready are both high.
//   out_ch carries status, next_pc, print data, flags and the stopped mark.
//   cfg_wr_en / cfg_wr_data write the cycle limit; write it only while the
//          unit is idle. It resets to 65535.
// Timing: the edge that takes an instruction beat also reads the register
//   file memory into the execute stage; the edge on which that stage
//   advances executes, writes back and loads the result register, from
//   which the result beat moves while out_ch.ready is high.
// Throughput: one instruction per cycle while out_ch.ready is high. A write on
//   the same edge as the following instruction's read is forwarded by a
//   one-entry bypass inside the register file.
// Reset: register file reads as zero (per entry valid bits), pc, flags,
//   halt mark and step count clear, both pipeline stages empty.
// Stall: while out_ch.ready is low the result holds; one more instruction
//   is taken into the execute stage, then in_ch.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module tiny_register_cpu_execute_unit import trce_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF,
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  trce_in_if.sink           in_ch,
  trce_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data
);

  rf_rd_t            rd;
  rf_wr_t            wr;
  logic [DATA_W-1:0] data_a;
  logic [DATA_W-1:0] data_b;

  // Issue operand reads on the edge that takes the instruction beat.
  assign rd.en     = in_ch.valid && in_ch.ready;
  assign rd.addr_a = in_ch.dest_index;
  assign rd.addr_b = in_ch.source_index;

  trce_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .wr     (wr),
    .data_a (data_a),
    .data_b (data_b)
  );

  trce_exec #(
    .REG_COUNT (REG_COUNT),
    .MEM_BYTES (MEM_BYTES)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .data_a      (data_a),
    .data_b      (data_b),
    .wr          (wr)
  );

  // Any error status leaves the machine stopped.
  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.stopped)
    else $error("error status without stopped mark");

  // Once a stopped result is delivered, every later result is stopped.
  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.stopped
    |=> !out_ch.valid || out_ch.stopped)
    else $error("machine resumed after stopping");

  // A print only comes from an executed instruction.
  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.print_valid |-> out_ch.status == ST_OK)
    else $error("print data on a failed instruction");

  // No register file write without an instruction in the execute stage.
  a_wr_needs_instr: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> out_ch.valid)
    else $error("register write without a result");

endmodule
